### sv/sre_pkg.sv
// ----------------------------------------------------------------------------
// sre_pkg
// Types and constants shared by the execute unit modules.
// ----------------------------------------------------------------------------
package sre_pkg;

  localparam int unsigned OpW = 5;
  localparam int unsigned RegW = 4;
  localparam int unsigned DataW = 32;
  localparam int unsigned ImmW = 27;
  localparam int unsigned StatusW = 2;
  localparam logic [RegW-1:0] LinkReg = 4'd15;
  localparam logic [4:0] ShiftMask = 5'h1F;

  typedef enum logic [OpW-1:0] {
    OP_ADD = 5'd0, OP_SUB = 5'd1, OP_MUL = 5'd2, OP_DIV = 5'd3, OP_MOD = 5'd4,
    OP_CMP = 5'd5, OP_AND = 5'd6, OP_OR = 5'd7, OP_NOT = 5'd8, OP_MOV = 5'd9,
    OP_LSL = 5'd10, OP_LSR = 5'd11, OP_ASR = 5'd12, OP_NOP = 5'd13,
    OP_LD = 5'd14, OP_ST = 5'd15, OP_B = 5'd16, OP_BEQ = 5'd17,
    OP_BGT = 5'd18, OP_CALL = 5'd19, OP_RET = 5'd20
  } op_t;

  typedef enum logic [StatusW-1:0] {
    ST_OK = 2'd0, ST_DIV_ZERO = 2'd1, ST_ADDR = 2'd2, ST_BAD_OP = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    IMM_SIGNED = 2'd0, IMM_LOW = 2'd1, IMM_HIGH = 2'd2
  } imm_mod_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_EXEC, S_DIV, S_MEM, S_MEM_WAIT, S_WRITE, S_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic is_mod;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [DataW-1:0] value;
  } div_rsp_t;

endpackage

### sv/sre_divider.sv
// ----------------------------------------------------------------------------
// sre_divider
// Signed radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sre_divider (
  input  logic                                 clk,
  input  logic                                 rst,
  input  sre_pkg::div_req_t                    req,
  output sre_pkg::div_rsp_t                    rsp
);

  localparam int unsigned W = sre_pkg::DataW;

  logic [W-1:0] quo;
  logic [W-1:0] rem;
  logic [W-1:0] den;
  logic [5:0] count;
  logic busy;
  logic neg_q;
  logic neg_r;
  logic is_mod;
  logic [W:0] trial;
  logic [W-1:0] rem_shift;
  logic [W-1:0] q_fix;
  logic [W-1:0] r_fix;

  assign rem_shift = {rem[W-2:0], quo[W-1]};
  assign trial = {1'b0, rem_shift} - {1'b0, den};
  assign q_fix = neg_q ? (~quo + 1'b1) : quo;
  assign r_fix = neg_r ? (~rem + 1'b1) : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rsp.done <= 1'b0;
      count <= '0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        count <= 6'd0;
        is_mod <= req.is_mod;
        neg_q <= req.a[W-1] ^ req.b[W-1];
        neg_r <= req.a[W-1];
        quo <= req.a[W-1] ? (~req.a + 1'b1) : req.a;
        den <= req.b[W-1] ? (~req.b + 1'b1) : req.b;
        rem <= '0;
      end else if (busy) begin
        if (count == 6'(W)) begin
          busy <= 1'b0;
          rsp.done <= 1'b1;
          rsp.value <= is_mod ? r_fix : q_fix;
        end else begin
          count <= count + 1'b1;
          if (!trial[W]) begin
            rem <= trial[W-1:0];
            quo <= {quo[W-2:0], 1'b1};
          end else begin
            rem <= rem_shift;
            quo <= {quo[W-2:0], 1'b0};
          end
        end
      end
    end
  end

endmodule

### sv/sre_data_mem.sv
// ----------------------------------------------------------------------------
// sre_data_mem
// Byte data memory as four byte lanes, a word write port and a word read port, registered read.
// ----------------------------------------------------------------------------
module sre_data_mem #(
  parameter int unsigned DATA_BYTES = 4096
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DATA_BYTES)-1:0]    addr,
  input  logic [31:0]                      wdata,
  input  logic                             re,
  input  logic [$clog2(DATA_BYTES)-1:0]    raddr,
  output logic [31:0]                      rdata
);

  localparam int unsigned AW = $clog2(DATA_BYTES);
  localparam int unsigned LW = (AW > 2) ? AW - 2 : 1;
  localparam int unsigned Rows = (DATA_BYTES + 3) / 4;

  logic [7:0] lane0 [Rows];
  logic [7:0] lane1 [Rows];
  logic [7:0] lane2 [Rows];
  logic [7:0] lane3 [Rows];
  logic [LW-1:0] wrow [4];
  logic [LW-1:0] rrow [4];
  logic [7:0] wb [4];
  logic [7:0] rb [4];
  logic [1:0] wsel;
  logic [1:0] rsel;
  logic [1:0] rsel_q;

  assign wsel = addr[1:0];
  assign rsel = raddr[1:0];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      wrow[i] = addr[AW-1:2] + LW'((i < int'(wsel)) ? 1 : 0);
      rrow[i] = raddr[AW-1:2] + LW'((i < int'(rsel)) ? 1 : 0);
      wb[i] = wdata[8*((i - int'(wsel)) & 3) +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      lane0[wrow[0]] <= wb[0];
      lane1[wrow[1]] <= wb[1];
      lane2[wrow[2]] <= wb[2];
      lane3[wrow[3]] <= wb[3];
    end
    if (re) begin
      rb[0] <= lane0[rrow[0]];
      rb[1] <= lane1[rrow[1]];
      rb[2] <= lane2[rrow[2]];
      rb[3] <= lane3[rrow[3]];
      rsel_q <= rsel;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rdata[8*i +: 8] = rb[(i + int'(rsel_q)) & 3];
    end
  end

endmodule

### sv/simple_risc_execute_unit_top.sv
// ----------------------------------------------------------------------------
// simple_risc_execute_unit_top
// Multicycle execute unit: register file, flags, pc and byte data memory.
// ----------------------------------------------------------------------------
// channel | dir | tdata fields, low bit first
// s_axis  | in  | operation, dest_reg, src_reg_a, src_reg_b, use_immediate,
//         |     | imm_modifier, immediate (47 bits, padded to 48)
// m_axis  | out | next_pc, status, reg_written, written_reg, written_value,
//         |     | equal_flag, greater_flag (73 bits, padded to 80)
// Most requests pass through read, execute, write and output states from accept
// to result; load and store add memory and memory-wait states; div and mod wait
// on the one-bit-per-cycle divider. After reset a clearing pass zeroes the data
// memory, during which s_axis_tready is low. A result waits in the output
// register until taken; the next request is accepted once it leaves.
module simple_risc_execute_unit_top #(
  parameter int unsigned DATA_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // operation, dest_reg, src_reg_a, src_reg_b,
                                     // use_immediate, imm_modifier, immediate
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata   // next_pc, status, reg_written, written_reg,
                                     // written_value, equal_flag, greater_flag
);

  localparam int unsigned AW = $clog2(DATA_BYTES);
  localparam int unsigned Rows = (DATA_BYTES + 3) / 4;
  localparam int unsigned CW = $clog2(Rows + 1);

  sre_pkg::state_t state, state_next;

  logic [4:0] operation;
  logic [3:0] dest_reg;
  logic [3:0] src_reg_a;
  logic [3:0] src_reg_b;
  logic use_immediate;
  logic [1:0] imm_modifier;
  logic [26:0] immediate;

  logic [31:0] regs [16];
  logic [31:0] pc;
  logic flag_eq;
  logic flag_gt;
  logic [31:0] opa;
  logic [31:0] opb;
  logic [31:0] st_data;
  logic [31:0] result;
  logic [31:0] result_next;
  logic [31:0] npc;
  logic [31:0] npc_next;
  logic [1:0] status;
  logic [1:0] status_next;
  logic wr;
  logic wr_next;
  logic [3:0] wreg;
  logic [3:0] wreg_next;
  logic feq_next;
  logic fgt_next;
  logic [CW-1:0] clr_cnt;
  logic [31:0] imm_sext;
  logic [31:0] imm_val;
  logic [32:0] addr_sum;
  logic addr_ok;
  logic [4:0] sh;

  sre_pkg::div_req_t div_req;
  sre_pkg::div_rsp_t div_rsp;

  logic mem_we;
  logic [AW-1:0] mem_addr;
  logic [31:0] mem_wdata;
  logic mem_re;
  logic [31:0] mem_rdata;

  assign imm_sext = {{5{immediate[26]}}, immediate};
  always_comb begin
    case (imm_modifier)
      sre_pkg::IMM_LOW: imm_val = {16'd0, immediate[15:0]};
      sre_pkg::IMM_HIGH: imm_val = {immediate[15:0], 16'd0};
      default: imm_val = imm_sext;
    endcase
  end

  assign addr_sum = {1'b0, opa + opb} + 33'd3;
  assign addr_ok = addr_sum < 33'(DATA_BYTES);
  assign sh = opb[4:0] & sre_pkg::ShiftMask;

  assign s_axis_tready = (state == sre_pkg::S_IDLE);

  sre_divider u_div (
    .clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp)
  );

  sre_data_mem #(.DATA_BYTES(DATA_BYTES)) u_mem (
    .clk(clk), .we(mem_we), .addr(mem_addr), .wdata(mem_wdata),
    .re(mem_re), .raddr(mem_addr), .rdata(mem_rdata)
  );

  always_comb begin
    div_req.start = (state == sre_pkg::S_EXEC) &&
                    (operation == sre_pkg::OP_DIV || operation == sre_pkg::OP_MOD) &&
                    (opb != 32'd0);
    div_req.is_mod = (operation == sre_pkg::OP_MOD);
    div_req.a = opa;
    div_req.b = opb;
    mem_re = (state == sre_pkg::S_MEM);
    mem_we = (state == sre_pkg::S_CLEAR) ||
             (state == sre_pkg::S_MEM && operation == sre_pkg::OP_ST);
    if (state == sre_pkg::S_CLEAR) begin
      mem_addr = AW'({clr_cnt, 2'b00});
      mem_wdata = '0;
    end else begin
      mem_addr = addr_sum[AW-1:0] - AW'(3);
      mem_wdata = st_data;
    end
  end

  // Execute: compute result, status, pc and flags from latched operands.
  always_comb begin
    result_next = '0;
    status_next = sre_pkg::ST_OK;
    wr_next = 1'b0;
    wreg_next = dest_reg;
    npc_next = pc + 32'd4;
    feq_next = flag_eq;
    fgt_next = flag_gt;
    case (operation)
      sre_pkg::OP_ADD: begin wr_next = 1'b1; result_next = opa + opb; end
      sre_pkg::OP_SUB: begin wr_next = 1'b1; result_next = opa - opb; end
      sre_pkg::OP_MUL: begin wr_next = 1'b1; result_next = opa * opb; end
      sre_pkg::OP_DIV, sre_pkg::OP_MOD: begin
        if (opb == 32'd0) status_next = sre_pkg::ST_DIV_ZERO;
        else wr_next = 1'b1;
      end
      sre_pkg::OP_CMP: begin
        feq_next = (opa == opb);
        fgt_next = $signed(opa) > $signed(opb);
      end
      sre_pkg::OP_AND: begin wr_next = 1'b1; result_next = opa & opb; end
      sre_pkg::OP_OR: begin wr_next = 1'b1; result_next = opa | opb; end
      sre_pkg::OP_NOT: begin wr_next = 1'b1; result_next = ~opa; end
      sre_pkg::OP_MOV: begin wr_next = 1'b1; result_next = opb; end
      sre_pkg::OP_LSL: begin wr_next = 1'b1; result_next = opa << sh; end
      sre_pkg::OP_LSR: begin wr_next = 1'b1; result_next = opa >> sh; end
      sre_pkg::OP_ASR: begin
        wr_next = 1'b1;
        result_next = 32'($signed(opa) >>> sh);
      end
      sre_pkg::OP_NOP: begin end
      sre_pkg::OP_LD: begin
        if (!addr_ok) status_next = sre_pkg::ST_ADDR;
        else wr_next = 1'b1;
      end
      sre_pkg::OP_ST: begin
        if (!addr_ok) status_next = sre_pkg::ST_ADDR;
      end
      sre_pkg::OP_B: npc_next = pc + {imm_sext[29:0], 2'b00};
      sre_pkg::OP_BEQ: if (flag_eq) npc_next = pc + {imm_sext[29:0], 2'b00};
      sre_pkg::OP_BGT: if (flag_gt) npc_next = pc + {imm_sext[29:0], 2'b00};
      sre_pkg::OP_CALL: begin
        wr_next = 1'b1;
        wreg_next = sre_pkg::LinkReg;
        result_next = pc + 32'd4;
        npc_next = pc + {imm_sext[29:0], 2'b00};
      end
      sre_pkg::OP_RET: npc_next = regs[sre_pkg::LinkReg];
      default: status_next = sre_pkg::ST_BAD_OP;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      sre_pkg::S_CLEAR:
        if (clr_cnt == CW'(Rows - 1)) state_next = sre_pkg::S_IDLE;
      sre_pkg::S_IDLE: if (s_axis_tvalid) state_next = sre_pkg::S_READ;
      sre_pkg::S_READ: state_next = sre_pkg::S_EXEC;
      sre_pkg::S_EXEC: begin
        if (div_req.start) state_next = sre_pkg::S_DIV;
        else if ((operation == sre_pkg::OP_LD || operation == sre_pkg::OP_ST) &&
                 addr_ok) state_next = sre_pkg::S_MEM;
        else state_next = sre_pkg::S_WRITE;
      end
      sre_pkg::S_DIV: if (div_rsp.done) state_next = sre_pkg::S_WRITE;
      sre_pkg::S_MEM: state_next = sre_pkg::S_MEM_WAIT;
      sre_pkg::S_MEM_WAIT: state_next = sre_pkg::S_WRITE;
      sre_pkg::S_WRITE: state_next = sre_pkg::S_OUT;
      sre_pkg::S_OUT: if (m_axis_tready) state_next = sre_pkg::S_IDLE;
      default: state_next = sre_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= sre_pkg::S_CLEAR;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      pc <= '0;
      flag_eq <= 1'b0;
      flag_gt <= 1'b0;
      for (int i = 0; i < 16; i++) regs[i] <= '0;
    end else begin
      case (state)
        sre_pkg::S_CLEAR: clr_cnt <= clr_cnt + 1'b1;
        sre_pkg::S_IDLE:
          if (s_axis_tvalid) begin
            operation <= s_axis_tdata[4:0];
            dest_reg <= s_axis_tdata[8:5];
            src_reg_a <= s_axis_tdata[12:9];
            src_reg_b <= s_axis_tdata[16:13];
            use_immediate <= s_axis_tdata[17];
            imm_modifier <= s_axis_tdata[19:18];
            immediate <= s_axis_tdata[46:20];
          end
        sre_pkg::S_READ: begin
          opa <= regs[src_reg_a];
          opb <= use_immediate ? imm_val : regs[src_reg_b];
          st_data <= regs[dest_reg];
        end
        sre_pkg::S_EXEC: begin
          result <= result_next;
          status <= status_next;
          wr <= wr_next;
          wreg <= wreg_next;
          npc <= npc_next;
          flag_eq <= feq_next;
          flag_gt <= fgt_next;
        end
        sre_pkg::S_DIV: if (div_rsp.done) result <= div_rsp.value;
        sre_pkg::S_MEM_WAIT: result <= mem_rdata;
        sre_pkg::S_WRITE: begin
          pc <= npc;
          if (wr) regs[wreg] <= result;
          else begin
            wreg <= '0;
            result <= '0;
          end
        end
        default: begin end
      endcase
    end
  end

  assign m_axis_tvalid = (state == sre_pkg::S_OUT);
  assign m_axis_tdata = {7'd0, flag_gt, flag_eq, result, wreg, wr, status, npc};

endmodule
